>>> rtl/core/grbf_pkg.sv
// Shared types, constants and tables for the Gaussian RBF energy and slope block.
package grbf_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Accumulator widths: one term magnitude stays below 2^46, one slope product below 2^54
  localparam int ESUM_W = 48 + CNT_W;
  localparam int SSUM_W = 56 + CNT_W;

  // Exponent unit: ln 2 in Q32, quotient digits, series length
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
  localparam int DIV_STEPS = 7;
  localparam int TERMS = 13;
  localparam int EXP_LAT = DIV_STEPS + 3 * (TERMS - 1) + 2;

  // floor(2^32 / n) for n = 2 .. 13
  localparam logic [31:0] RECIP [TERMS-1] = '{
    32'h8000_0000, 32'h5555_5555, 32'h4000_0000, 32'h3333_3333,
    32'h2AAA_AAAA, 32'h2492_4924, 32'h2000_0000, 32'h1C71_C71C,
    32'h1999_9999, 32'h1745_D174, 32'h1555_5555, 32'h13B1_3B13
  };

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAUSS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAUSS_RATE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT    = 2'd3;

  typedef struct packed {
    logic               op;
    logic [5:0]         entry_index;
    logic signed [31:0] center_value;
    logic signed [31:0] weight_value;
    logic signed [31:0] density;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] energy;
    logic signed [47:0] slope;
  } out_word_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] density;
    logic [31:0] center;
    logic [31:0] weight;
  } term_in_t;

  typedef struct packed {
    logic        valid;
    logic        tneg;
    logic        pneg;
    logic [46:0] tmag;
    logic [54:0] pmag;
  } term_out_t;

endpackage

>>> rtl/core/grbf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module grbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/grbf_exp.sv
// Pipelined exp(-x): Q24 argument in, Q32 result out.
module grbf_exp (
  input  logic        clk,
  input  logic [29:0] x,
  output logic [32:0] g
);
  import grbf_pkg::*;

  typedef struct packed {
    logic [31:0]        f;
    logic [6:0]         k;
    logic signed [34:0] s;
  } exp_ctx_t;

  // Range reduction by ln 2, one quotient digit per stage
  logic [37:0] dv_src    [DIV_STEPS];
  logic [6:0]  dv_ksrc   [DIV_STEPS];
  logic [37:0] dv_rem_r  [DIV_STEPS];
  logic [37:0] dv_rem_nxt[DIV_STEPS];
  logic [6:0]  dv_k_r    [DIV_STEPS];
  logic [6:0]  dv_k_nxt  [DIV_STEPS];

  // Series: multiply, reciprocal multiply, correct and accumulate per term
  logic [31:0] tc_r   [TERMS];
  logic [31:0] tc_nxt [TERMS];
  exp_ctx_t    cc_r   [TERMS];
  exp_ctx_t    cc_nxt [TERMS];
  logic [63:0] pa_r   [TERMS-1];
  logic [63:0] pa_nxt [TERMS-1];
  exp_ctx_t    ca_r   [TERMS-1];
  exp_ctx_t    ca_nxt [TERMS-1];
  logic [31:0] vb_r   [TERMS-1];
  logic [31:0] vb_nxt [TERMS-1];
  logic [63:0] pmb_r  [TERMS-1];
  logic [63:0] pmb_nxt[TERMS-1];
  exp_ctx_t    cb_r   [TERMS-1];
  exp_ctx_t    cb_nxt [TERMS-1];

  logic [32:0] g_r, g_nxt;

  always_comb begin
    logic [37:0] step;
    dv_src[0]  = {x, 8'b0};
    dv_ksrc[0] = '0;
    for (int i = 1; i < DIV_STEPS; i++) begin
      dv_src[i]  = dv_rem_r[i-1];
      dv_ksrc[i] = dv_k_r[i-1];
    end
    for (int i = 0; i < DIV_STEPS; i++) begin
      step = 38'(LN2_Q32) << (DIV_STEPS - 1 - i);
      if (dv_src[i] >= step) begin
        dv_rem_nxt[i] = dv_src[i] - step;
        dv_k_nxt[i]   = dv_ksrc[i] | (7'd1 << (DIV_STEPS - 1 - i));
      end else begin
        dv_rem_nxt[i] = dv_src[i];
        dv_k_nxt[i]   = dv_ksrc[i];
      end
    end
  end

  always_comb begin
    logic [31:0] q0;
    logic [31:0] rm;
    logic [31:0] q;
    logic [31:0] f0;
    f0 = dv_rem_r[DIV_STEPS-1][31:0];
    // first term is f itself
    tc_nxt[0]   = f0;
    cc_nxt[0].f = f0;
    cc_nxt[0].k = dv_k_r[DIV_STEPS-1];
    cc_nxt[0].s = $signed(35'h1_0000_0000 - {3'b0, f0});
    for (int j = 0; j < TERMS - 1; j++) begin
      pa_nxt[j]  = 64'(tc_r[j]) * 64'(cc_r[j].f);
      ca_nxt[j]  = cc_r[j];
      vb_nxt[j]  = pa_r[j][63:32];
      pmb_nxt[j] = 64'(pa_r[j][63:32]) * 64'(RECIP[j]);
      cb_nxt[j]  = ca_r[j];
      // reciprocal estimate is exact or one low
      q0 = pmb_r[j][63:32];
      rm = vb_r[j] - 32'(q0 * 32'(j + 2));
      q  = (rm >= 32'(j + 2)) ? q0 + 32'd1 : q0;
      tc_nxt[j+1] = q;
      cc_nxt[j+1] = cb_r[j];
      if ((j % 2) == 0) begin
        cc_nxt[j+1].s = cb_r[j].s + $signed({3'b0, q});
      end else begin
        cc_nxt[j+1].s = cb_r[j].s - $signed({3'b0, q});
      end
    end
  end

  always_comb begin
    logic [34:0] sh;
    sh = cc_r[TERMS-1].s >> cc_r[TERMS-1].k;
    g_nxt = (cc_r[TERMS-1].k < 7'd63) ? sh[32:0] : '0;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      dv_rem_r[i] <= dv_rem_nxt[i];
      dv_k_r[i]   <= dv_k_nxt[i];
    end
    for (int j = 0; j < TERMS; j++) begin
      tc_r[j] <= tc_nxt[j];
      cc_r[j] <= cc_nxt[j];
    end
    for (int j = 0; j < TERMS - 1; j++) begin
      pa_r[j]  <= pa_nxt[j];
      ca_r[j]  <= ca_nxt[j];
      vb_r[j]  <= vb_nxt[j];
      pmb_r[j] <= pmb_nxt[j];
      cb_r[j]  <= cb_nxt[j];
    end
    g_r <= g_nxt;
  end

  assign g = g_r;

endmodule

>>> rtl/core/grbf_term.sv
// Per-entry datapath: distance, Gaussian argument, exponent, weighted term and slope product.
module grbf_term (
  input  logic                clk,
  input  logic                rst_n,
  input  grbf_pkg::term_in_t  term_in,
  input  logic [30:0]         gauss_height,
  input  logic [30:0]         gauss_rate,
  output grbf_pkg::term_out_t term_out
);
  import grbf_pkg::*;

  typedef struct packed {
    logic        dneg;
    logic        wneg;
    logic [31:0] dmag;
    logic [45:0] whs;
  } side_t;

  // S1: distance and weight magnitudes
  logic        s1_v_r;
  logic        s1_dneg_r, s1_wneg_r;
  logic [31:0] s1_dmag_r, s1_wabs_r;
  // S2: square and weight times height
  logic        s2_v_r;
  logic        s2_dneg_r, s2_wneg_r;
  logic [31:0] s2_dmag_r;
  logic [63:0] s2_sq_r;
  logic [62:0] s2_wh_r;
  // S3: rate times square, split in two partial products
  logic        s3_v_r;
  logic        s3_dneg_r, s3_wneg_r;
  logic [31:0] s3_dmag_r;
  logic [45:0] s3_whs_r;
  logic [62:0] s3_plo_r;
  logic [38:0] s3_phi_r;
  // S4 and exponent alignment
  logic [29:0]      x_r;
  side_t            side_r [EXP_LAT+1];
  logic [EXP_LAT:0] sv_r;
  logic [32:0]      g;
  // S5..S8: term and slope product
  logic        s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic        s5_dneg_r, s5_wneg_r, s6_dneg_r, s6_wneg_r, s7_dneg_r, s7_wneg_r;
  logic [31:0] s5_dmag_r, s6_dmag_r, s7_dmag_r;
  logic [64:0] s5_mlo_r;
  logic [46:0] s5_mhi_r;
  logic [46:0] s6_tmag_r, s7_tmag_r, s8_tmag_r;
  logic [63:0] s7_qlo_r;
  logic [46:0] s7_qhi_r;
  logic [54:0] s8_pmag_r;
  logic        s8_tneg_r, s8_pneg_r;

  logic [32:0] diff;
  logic [70:0] xfull;
  logic [78:0] pfull;

  assign diff  = {term_in.density[31], term_in.density} - {term_in.center[31], term_in.center};
  assign xfull = {8'b0, s3_plo_r} + {s3_phi_r, 32'b0};
  assign pfull = {15'b0, s7_qlo_r} + {s7_qhi_r, 32'b0};

  grbf_exp u_exp (
    .clk (clk),
    .x   (x_r),
    .g   (g)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      sv_r   <= '0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else begin
      s1_v_r <= term_in.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      sv_r   <= {sv_r[EXP_LAT-1:0], s3_v_r};
      s5_v_r <= sv_r[EXP_LAT];
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_dneg_r <= diff[32];
    s1_dmag_r <= diff[32] ? 32'(33'd0 - diff) : diff[31:0];
    s1_wneg_r <= term_in.weight[31];
    s1_wabs_r <= term_in.weight[31] ? (~term_in.weight + 32'd1) : term_in.weight;

    s2_dneg_r <= s1_dneg_r;
    s2_wneg_r <= s1_wneg_r;
    s2_dmag_r <= s1_dmag_r;
    s2_sq_r   <= 64'(s1_dmag_r) * 64'(s1_dmag_r);
    s2_wh_r   <= 63'(s1_wabs_r) * 63'(gauss_height);

    s3_dneg_r <= s2_dneg_r;
    s3_wneg_r <= s2_wneg_r;
    s3_dmag_r <= s2_dmag_r;
    s3_whs_r  <= s2_wh_r[61:16];
    s3_plo_r  <= 63'(gauss_rate) * 63'(s2_sq_r[55:24]);
    s3_phi_r  <= 39'(gauss_rate) * 39'(s2_sq_r[63:56]);

    // argument at or above 2^30 drives the exponent to zero
    x_r <= (|xfull[70:54]) ? '1 : xfull[53:24];
    side_r[0] <= '{dneg: s3_dneg_r, wneg: s3_wneg_r, dmag: s3_dmag_r, whs: s3_whs_r};
    for (int i = 1; i <= EXP_LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end

    s5_dneg_r <= side_r[EXP_LAT].dneg;
    s5_wneg_r <= side_r[EXP_LAT].wneg;
    s5_dmag_r <= side_r[EXP_LAT].dmag;
    s5_mlo_r  <= 65'(g) * 65'(side_r[EXP_LAT].whs[31:0]);
    s5_mhi_r  <= 47'(g) * 47'(side_r[EXP_LAT].whs[45:32]);

    s6_dneg_r <= s5_dneg_r;
    s6_wneg_r <= s5_wneg_r;
    s6_dmag_r <= s5_dmag_r;
    s6_tmag_r <= s5_mhi_r + 47'(s5_mlo_r[64:32]);

    s7_dneg_r <= s6_dneg_r;
    s7_wneg_r <= s6_wneg_r;
    s7_dmag_r <= s6_dmag_r;
    s7_tmag_r <= s6_tmag_r;
    s7_qlo_r  <= 64'(s6_tmag_r[31:0]) * 64'(s6_dmag_r);
    s7_qhi_r  <= 47'(s6_tmag_r[46:32]) * 47'(s6_dmag_r);

    s8_tmag_r <= s7_tmag_r;
    s8_pmag_r <= pfull[78:24];
    s8_tneg_r <= s7_wneg_r;
    s8_pneg_r <= s7_wneg_r ^ s7_dneg_r;
  end

  assign term_out = '{valid: s8_v_r, tneg: s8_tneg_r, pneg: s8_pneg_r,
                      tmag: s8_tmag_r, pmag: s8_pmag_r};

endmodule

>>> rtl/core/gaussian_rbf_energy_and_slope.sv
// Top level: table RAMs, entry sequencer, accumulators, final scaling and result register.
// Load word: taken when the block is idle; loads may follow back to back.
// Evaluate word: min(basis_count, MAX_ENTRIES) entries are read, one entry read per cycle
//   through a 53-stage term pipeline.
// One evaluate at a time; the next word is taken once the result sits in the output register.
// Reset: control and configuration return to defaults; table contents are not cleared.
module gaussian_rbf_energy_and_slope (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  grbf_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output grbf_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [grbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);
  import grbf_pkg::*;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_RUN  = 3'd1;
  localparam logic [ST_W-1:0] ST_FIN1 = 3'd2;
  localparam logic [ST_W-1:0] ST_FIN2 = 3'd3;
  localparam logic [ST_W-1:0] ST_FIN3 = 3'd4;
  localparam logic [ST_W-1:0] ST_HOLD = 3'd5;
  localparam int FULL_W = SSUM_W + 32;

  // Configuration
  logic [6:0]  basis_count_r;
  logic [30:0] gauss_height_r;
  logic [30:0] gauss_rate_r;
  logic [31:0] intercept_r;

  // Sequencer
  logic [ST_W-1:0]  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic [31:0]      dens_r;
  logic             rd_v_r;
  logic             rd_en;
  logic             in_acc;
  logic             load_we;
  logic             take_ok;

  // Table RAM read data
  logic [31:0] center_rd, weight_rd;

  // Term pipeline
  term_in_t  term_in;
  term_out_t term_out;

  // Accumulators
  logic signed [ESUM_W-1:0] esum_r, esum_nxt;
  logic signed [SSUM_W-1:0] ssum_r, ssum_nxt;

  // Final scaling
  logic signed [ESUM_W:0] ea_r;
  logic [SSUM_W-1:0]      smag_r;
  logic                   spos_r, spos2_r;
  logic [63:0]            slo_r;
  logic [SSUM_W-1:0]      shi_r;
  logic [47:0]            energy_r;
  logic [FULL_W-1:0]      sfull;
  logic                   mag_big;
  logic [47:0]            mag48;
  logic                   e_ovf;
  out_word_t              res_r;

  // Result register
  out_word_t out_r;
  logic      out_valid_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_we   = in_acc && (in_data.op == OP_LOAD)
                     && (32'(in_data.entry_index) < 32'(MAX_ENTRIES));
  assign rd_en     = (state_r == ST_RUN) && (issue_r < cnt_r);
  assign take_ok   = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Count is clamped to the table depth at the start of an evaluation
  assign cnt_nxt = (32'(basis_count_r) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                           : CNT_W'(basis_count_r);

  grbf_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_center_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (IDX_W'(in_data.entry_index)),
    .wdata (in_data.center_value),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (center_rd)
  );

  grbf_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_weight_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (IDX_W'(in_data.entry_index)),
    .wdata (in_data.weight_value),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (weight_rd)
  );

  assign term_in = '{valid: rd_v_r, density: dens_r, center: center_rd, weight: weight_rd};

  grbf_term u_term (
    .clk          (clk),
    .rst_n        (rst_n),
    .term_in      (term_in),
    .gauss_height (gauss_height_r),
    .gauss_rate   (gauss_rate_r),
    .term_out     (term_out)
  );

  // Sequencer: issue one read per cycle, count accumulated terms, then scale and hand off
  always_comb begin
    state_nxt = state_r;
    issue_nxt = issue_r;
    acc_nxt   = acc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.op == OP_EVAL)) begin
          state_nxt = ST_RUN;
          issue_nxt = '0;
          acc_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (rd_en) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        if (term_out.valid) begin
          acc_nxt = acc_r + CNT_W'(1);
        end
        if (acc_r == cnt_r) begin
          state_nxt = ST_FIN1;
        end
      end
      ST_FIN1: state_nxt = ST_FIN2;
      ST_FIN2: state_nxt = ST_FIN3;
      ST_FIN3: state_nxt = ST_HOLD;
      ST_HOLD: begin
        if (take_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Signed accumulation of terms and slope products
  always_comb begin
    esum_nxt = esum_r;
    ssum_nxt = ssum_r;
    if (in_acc && (in_data.op == OP_EVAL)) begin
      esum_nxt = '0;
      ssum_nxt = '0;
    end else if (term_out.valid) begin
      esum_nxt = term_out.tneg ? esum_r - $signed(ESUM_W'(term_out.tmag))
                               : esum_r + $signed(ESUM_W'(term_out.tmag));
      ssum_nxt = term_out.pneg ? ssum_r - $signed(SSUM_W'(term_out.pmag))
                               : ssum_r + $signed(SSUM_W'(term_out.pmag));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      issue_r        <= '0;
      acc_r          <= '0;
      rd_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      basis_count_r  <= 7'd64;
      gauss_height_r <= 31'd16777216;
      gauss_rate_r   <= 31'd8388608;
      intercept_r    <= '0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
      acc_r   <= acc_nxt;
      rd_v_r  <= rd_en;
      // hand the result word over, or drop it once taken
      if ((state_r == ST_HOLD) && take_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BASIS_COUNT:  basis_count_r  <= cfg_data[6:0];
          REG_GAUSS_HEIGHT: gauss_height_r <= cfg_data[30:0];
          REG_GAUSS_RATE:   gauss_rate_r   <= cfg_data[30:0];
          REG_INTERCEPT:    intercept_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Final scaling: free running, inputs hold still from the end of accumulation
  assign sfull   = FULL_W'(slo_r) + {shi_r, 32'b0};
  assign mag_big = |sfull[FULL_W-1:71];
  assign mag48   = mag_big ? 48'h8000_0000_0000 : {1'b0, sfull[70:24]};
  assign e_ovf   = (ea_r[ESUM_W:47] != {(ESUM_W - 46){ea_r[ESUM_W]}});

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.op == OP_EVAL)) begin
      dens_r <= in_data.density;
      cnt_r  <= cnt_nxt;
    end
    esum_r <= esum_nxt;
    ssum_r <= ssum_nxt;

    // FIN1: magnitude of slope sum, energy plus intercept in Q16.32
    smag_r <= ssum_r[SSUM_W-1] ? SSUM_W'(-ssum_r) : SSUM_W'(ssum_r);
    spos_r <= !ssum_r[SSUM_W-1] && (ssum_r != '0);
    ea_r   <= (ESUM_W+1)'(esum_r) + (ESUM_W+1)'($signed({intercept_r, 8'b0}));

    // FIN2: scale by twice the rate in two partial products, clamp energy
    slo_r    <= 64'(smag_r[31:0]) * 64'({gauss_rate_r, 1'b0});
    shi_r    <= SSUM_W'(smag_r[SSUM_W-1:32]) * SSUM_W'({gauss_rate_r, 1'b0});
    spos2_r  <= spos_r;
    energy_r <= e_ovf ? (ea_r[ESUM_W] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF)
                      : ea_r[47:0];

    // FIN3: slope takes the opposite sign of the sum, capped at 2^47
    res_r.energy <= energy_r;
    res_r.slope  <= spos2_r ? (48'd0 - mag48)
                            : (mag_big ? 48'h7FFF_FFFF_FFFF : mag48);

    if ((state_r == ST_HOLD) && take_ok) begin
      out_r <= res_r;
    end
  end

  // Reads never run past the clamped count
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (issue_r <= cnt_r))
    else $error("entry issue past count");

  // No more terms arrive than were read
  assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= issue_r)
    else $error("term count ahead of reads");

  // Terms land only while the sequencer is collecting them
  assert property (@(posedge clk) disable iff (!rst_n)
    term_out.valid |-> (state_r == ST_RUN))
    else $error("term word outside run");

  // A result word appears only from the hand-off state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_HOLD))
    else $error("result word without hand-off");

endmodule

>>> dv/tb.sv
// Testbench for the Gaussian RBF energy and slope block: directed and random words, self-checking.
`timescale 1ns / 100ps

module tb;
  import grbf_pkg::*;

  typedef longint unsigned u64_t;

  localparam u64_t LN2_C     = 64'hB172_17F8;
  localparam u64_t PROD_CAP  = (64'd1 << 54) - 64'd1;
  localparam longint POS_MAX = (64'sd1 <<< 47) - 64'sd1;
  localparam longint NEG_MIN = -(64'sd1 <<< 47);
  localparam int SETTLE      = 160;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Shadow state of the block
  logic [31:0] center_mem [MAX_ENTRIES];
  logic [31:0] weight_mem [MAX_ENTRIES];
  bit          loaded [MAX_ENTRIES];
  logic [6:0]  count_reg;
  logic [30:0] height_reg;
  logic [30:0] rate_reg;
  logic [31:0] intercept_reg;

  out_word_t energy_slope_q [$];
  int  err_cnt = 0;
  bit  idle_on = 1'b1;
  int  out_hold = 0;

  gaussian_rbf_energy_and_slope u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Limit the run even if the block hangs
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // floor(a*b / 2^s), capped
  function automatic u64_t mul_shift(u64_t a, u64_t b, int s, u64_t cap);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return (p > {64'd0, cap}) ? cap : p[63:0];
  endfunction

  // exp(-x) with x in Q24, result in Q32
  function automatic u64_t exp_neg(u64_t x24);
    u64_t xq, k, f, t;
    longint acc;
    xq = x24 << 8;
    k = xq / LN2_C;
    f = xq - k * LN2_C;
    t = 64'd1 << 32;
    acc = 64'sd1 <<< 32;
    for (int n = 1; n <= 13; n++) begin
      t = ((t * f) >> 32) / u64_t'(n);
      if (n % 2 == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    if (k >= 63) return 0;
    return u64_t'(acc) >> k;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < NEG_MIN) return NEG_MIN;
    return v;
  endfunction

  function automatic out_word_t predict_energy_slope(logic [31:0] dens);
    out_word_t r;
    int     n;
    longint d, diff, w, esum, ssum, en, sl;
    u64_t   dmag, sq, g, tmag, pmag, smag, mag;
    d = longint'($signed(dens));
    n = (count_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_reg);
    esum = 0;
    ssum = 0;
    for (int i = 0; i < n; i++) begin
      diff = d - longint'($signed(center_mem[i]));
      w = longint'($signed(weight_mem[i]));
      dmag = (diff < 0) ? u64_t'(-diff) : u64_t'(diff);
      sq = mul_shift(dmag, dmag, 24, 64'hFFFF_FFFF_FFFF_FFFF);
      if (rate_reg == 0) g = exp_neg(0);
      else if (sq > PROD_CAP / u64_t'(rate_reg)) g = 0;
      else g = exp_neg((u64_t'(rate_reg) * sq) >> 24);
      tmag = mul_shift(((w < 0) ? u64_t'(-w) : u64_t'(w)) * u64_t'(height_reg) >> 16,
                       g, 32, 64'hFFFF_FFFF_FFFF_FFFF);
      pmag = mul_shift(tmag, dmag, 24, 64'hFFFF_FFFF_FFFF_FFFF);
      esum = esum + ((w < 0) ? -longint'(tmag) : longint'(tmag));
      ssum = ssum + (((w < 0) != (diff < 0)) ? -longint'(pmag) : longint'(pmag));
    end
    en = clamp48(esum + longint'($signed(intercept_reg)) * 256);
    smag = (ssum < 0) ? u64_t'(-ssum) : u64_t'(ssum);
    mag = mul_shift(smag, u64_t'(rate_reg) * 2, 24, 64'd1 << 47);
    if (ssum > 0) sl = -longint'(mag);
    else sl = clamp48(longint'(mag));
    r.energy = en[47:0];
    r.slope = sl[47:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, compare each accepted word
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      out_hold <= $urandom_range(1, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (energy_slope_q.size() == 0) begin
        $display("%0t: unexpected result energy=%h slope=%h", $time,
                 out_data.energy, out_data.slope);
        err_cnt++;
      end else begin
        exp_w = energy_slope_q.pop_front();
        if (out_data.energy !== exp_w.energy) begin
          $display("%0t: energy expected %h actual %h", $time, exp_w.energy,
                   out_data.energy);
          err_cnt++;
        end
        if (out_data.slope !== exp_w.slope) begin
          $display("%0t: slope expected %h actual %h", $time, exp_w.slope,
                   out_data.slope);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one word; valid stays high into the next word unless a gap is drawn.
  task automatic send_word(in_word_t w);
    in_data = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.op == OP_LOAD) begin
      center_mem[w.entry_index] = w.center_value;
      weight_mem[w.entry_index] = w.weight_value;
      loaded[w.entry_index] = 1'b1;
    end else begin
      energy_slope_q.push_back(predict_energy_slope(w.density));
    end
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task automatic load_entry(int idx, logic [31:0] c, logic [31:0] w);
    in_word_t x;
    x = '0;
    x.op = OP_LOAD;
    x.entry_index = idx[5:0];
    x.center_value = c;
    x.weight_value = w;
    x.density = $urandom();
    send_word(x);
  endtask

  task automatic eval_at(logic [31:0] dens);
    in_word_t x;
    x = '0;
    x.op = OP_EVAL;
    x.entry_index = 6'($urandom());
    x.center_value = $urandom();
    x.weight_value = $urandom();
    x.density = dens;
    send_word(x);
  endtask

  // Drain, let any trailing load settle, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    in_valid = 1'b0;
    @(negedge clk);
    while (energy_slope_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_BASIS_COUNT:  count_reg = val[6:0];
      REG_GAUSS_HEIGHT: height_reg = val[30:0];
      REG_GAUSS_RATE:   rate_reg = val[30:0];
      REG_INTERCEPT:    intercept_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly values near the centers, sometimes extremes or full range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endcase
  endfunction

  function automatic int active_entries();
    return (count_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_reg);
  endfunction

  // Random well-formed traffic: evaluate only once every active entry holds data.
  task automatic random_words(int n_words);
    int gap;
    for (int k = 0; k < n_words; k++) begin
      gap = -1;
      for (int i = 0; i < active_entries(); i++)
        if (!loaded[i] && gap < 0) gap = i;
      if (gap >= 0) load_entry(gap, pick_value(), pick_value());
      else if ($urandom_range(0, 2) == 0)
        load_entry($urandom_range(0, MAX_ENTRIES - 1), pick_value(), pick_value());
      else eval_at(pick_value());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single entry: extremes of center, weight and density, zero distance.
  task automatic test_single_entry();
    write_reg(REG_BASIS_COUNT, 32'd1);
    load_entry(0, 32'h0000_0000, 32'h0100_0000);
    eval_at(32'h0000_0000);
    eval_at(32'h0080_0000);
    eval_at(32'hFF80_0000);
    eval_at(32'h7FFF_FFFF);
    eval_at(32'h8000_0000);
    load_entry(0, 32'h7FFF_FFFF, 32'h8000_0000);
    eval_at(32'h8000_0000);
    eval_at(32'h7FFF_FFFF);
    load_entry(0, 32'h8000_0000, 32'h7FFF_FFFF);
    eval_at(32'h8000_0000);
    eval_at(32'h8000_4000);
    load_entry(63, 32'h0120_0000, 32'hFF00_0000);
  endtask

  // Register extremes: empty sum, intercept, rate and height corners.
  task automatic test_register_extremes();
    write_reg(REG_BASIS_COUNT, 32'd0);
    write_reg(REG_INTERCEPT, 32'h7FFF_FFFF);
    eval_at(32'h0100_0000);
    write_reg(REG_INTERCEPT, 32'h8000_0000);
    eval_at(32'h8000_0000);
    write_reg(REG_BASIS_COUNT, 32'd1);
    write_reg(REG_GAUSS_RATE, 32'd0);
    write_reg(REG_GAUSS_HEIGHT, 32'h7FFF_FFFF);
    load_entry(0, 32'h0000_0000, 32'h7FFF_FFFF);
    eval_at(32'h7FFF_FFFF);
    eval_at(32'h8000_0000);
    write_reg(REG_GAUSS_RATE, 32'h7FFF_FFFF);
    eval_at(32'h0000_0001);
    eval_at(32'h0000_0000);
    write_reg(REG_GAUSS_HEIGHT, 32'd0);
    eval_at(32'h0000_1000);
  endtask

  // Random traffic across several register settings; the last has no idling.
  task automatic test_random_settings();
    write_reg(REG_GAUSS_HEIGHT, 32'h0100_0000);
    write_reg(REG_GAUSS_RATE, 32'h0080_0000);
    write_reg(REG_INTERCEPT, 32'h0000_0000);
    write_reg(REG_BASIS_COUNT, 32'd4);
    random_words(250);
    write_reg(REG_BASIS_COUNT, 32'd127);
    random_words(150);
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_BASIS_COUNT, $urandom_range(0, 16));
      write_reg(REG_GAUSS_HEIGHT, $urandom_range(0, 32'h0400_0000));
      write_reg(REG_GAUSS_RATE, ($urandom_range(0, 3) == 0) ? $urandom() :
                                $urandom_range(0, 32'h0200_0000));
      write_reg(REG_INTERCEPT, $urandom());
      random_words(180);
    end
    idle_on = 1'b0;
    write_reg(REG_BASIS_COUNT, 32'd64);
    random_words(150);
  endtask

  initial begin
    for (int i = 0; i < MAX_ENTRIES; i++) loaded[i] = 1'b0;
    count_reg = 7'd64;
    height_reg = 31'h0100_0000;
    rate_reg = 31'h0080_0000;
    intercept_reg = 32'h0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_single_entry();
    test_register_extremes();
    test_random_settings();
    in_valid = 1'b0;
    @(negedge clk);
    while (energy_slope_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/grbf_pkg.sv
rtl/core/grbf_ram.sv
rtl/core/grbf_exp.sv
rtl/core/grbf_term.sv
rtl/core/gaussian_rbf_energy_and_slope.sv
dv/tb.sv
